[sv/sadf_pkg.sv]
// sadf_pkg: shared types and constants of the set associative duplicate filter
// depends on nothing; imported by the interfaces and by every module of the block but sadf_tag_ram
package sadf_pkg;

	localparam int VERTEX_W   = 32;
	localparam int WAYS       = 4;
	localparam int WAY_W      = 2;
	localparam int EPOCH_BITS = 8;
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = 2;
	localparam int OUT_CNT_W  = 3;

	typedef logic [WAY_W-1:0]      way_t;
	typedef logic [EPOCH_BITS-1:0] epoch_t;

	// epoch zero marks entries written by the clearing pass, never current
	localparam epoch_t EPOCH_FIRST = epoch_t'(1);
	localparam epoch_t EPOCH_LAST  = '1;

	localparam logic CMD_VERTEX = 1'b0;
	localparam logic CMD_END    = 1'b1;

	typedef struct packed {
		logic [VERTEX_W-1:0] vertex_out;
		logic                is_end;
	} out_item_t;

endpackage

[sv/sadf_in_if.sv]
// sadf_in_if: input channel of the duplicate filter, valid/ready plus item fields
// depends on sadf_pkg
interface sadf_in_if import sadf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [VERTEX_W-1:0] vertex_in;

	modport source (output valid, output cmd, output vertex_in, input ready);
	modport sink   (input valid, input cmd, input vertex_in, output ready);
endinterface

[sv/sadf_out_if.sv]
// sadf_out_if: result channel of the duplicate filter, valid/ready plus result fields
// depends on sadf_pkg
interface sadf_out_if import sadf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VERTEX_W-1:0] vertex_out;
	logic                is_end;

	modport source (output valid, output vertex_out, output is_end, input ready);
	modport sink   (input valid, input vertex_out, input is_end, output ready);
endinterface

[sv/sadf_tag_ram.sv]
// sadf_tag_ram: one synchronous memory holding all ways of a set in one word
// depends on nothing; read data registered, read before write on the same edge
module sadf_tag_ram #(
	parameter int SET_BITS = 14,
	parameter int WORD_W   = 104
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [SET_BITS-1:0] rd_addr,
	output logic [WORD_W-1:0]   rd_data,
	input  logic                wr_en,
	input  logic [SET_BITS-1:0] wr_addr,
	input  logic [WORD_W-1:0]   wr_data
);

	logic [WORD_W-1:0] mem [2**SET_BITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/sadf_match.sv]
// sadf_match: four-way tag compare with epoch check and victim way update
// depends on sadf_pkg
module sadf_match import sadf_pkg::*; #(
	parameter int TAG_W = 18
) (
	input  logic [WAYS-1:0][EPOCH_BITS+TAG_W-1:0] word,
	input  logic [TAG_W-1:0]                      tag,
	input  epoch_t                                epoch,
	input  way_t                                  victim,
	output logic                                  hit,
	output logic [WAYS-1:0][EPOCH_BITS+TAG_W-1:0] new_word
);

	logic [WAYS-1:0] way_hit;

	// an entry from an older epoch reads as the all-ones cleared tag
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (word[w][EPOCH_BITS+TAG_W-1:TAG_W] == epoch) begin
				way_hit[w] = (word[w][TAG_W-1:0] == tag);
			end else begin
				way_hit[w] = (tag == '1);
			end
		end
		hit = |way_hit;
	end

	always_comb begin
		new_word         = word;
		new_word[victim] = {epoch, tag};
	end

endmodule

[sv/sadf_out_fifo.sv]
// sadf_out_fifo: small result queue that decouples the lookup stage from the sink
// depends on sadf_pkg and sadf_out_if
module sadf_out_fifo import sadf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  out_item_t            push_item,
	output logic [OUT_CNT_W-1:0] level,
	sadf_out_if.source           results
);

	out_item_t              slot_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]   wr_ptr_q;
	logic [OUT_PTR_W-1:0]   rd_ptr_q;
	logic [OUT_CNT_W-1:0]   count_q;
	logic                   pop;

	assign pop                = results.valid && results.ready;
	assign results.valid      = (count_q != '0);
	assign results.vertex_out = slot_q[rd_ptr_q].vertex_out;
	assign results.is_end     = slot_q[rd_ptr_q].is_end;
	assign level              = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			count_q <= count_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
		end
	end

endmodule

[sv/set_assoc_duplicate_filter.sv]
// set_assoc_duplicate_filter: top level of the four-way vertex duplicate filter
// depends on sadf_pkg, sadf_in_if, sadf_out_if, sadf_tag_ram, sadf_match, sadf_out_fifo
//
// channel   role    transaction carries
// items     sink    cmd, vertex_in
// results   source  vertex_out, is_end
//
// one vertex per cycle sustained while items is ready; an item is looked up the cycle
// after its transaction and its result can leave the cycle after that
// the rate rests on the separate read and write ports of the tag memory, used as one
// read-modify-write per item, with a one-entry write forward covering back-to-back
// items on the same set; after reset, and after every 255th end marker, a clearing
// pass rewrites every set of the tag memory while items is held not ready
// items also stalls while a wrapping end marker is looked up, and whenever queued
// plus in-flight results fill the four-entry result queue
module set_assoc_duplicate_filter import sadf_pkg::*; #(
	parameter int SET_INDEX_BITS = 14,
	parameter int VERTEX_BITS    = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	sadf_in_if.sink   items,
	sadf_out_if.source results
);

	localparam int  TAG_BITS = (VERTEX_BITS > SET_INDEX_BITS) ? VERTEX_BITS - SET_INDEX_BITS : 0;
	localparam int  TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
	localparam bit  HAS_TAG  = (TAG_BITS > 0);
	localparam int  ENTRY_W  = EPOCH_BITS + TAG_W;
	localparam int  WORD_W   = WAYS * ENTRY_W;
	localparam logic [VERTEX_W-1:0] VMASK = VERTEX_W'((64'd1 << VERTEX_BITS) - 64'd1);

	typedef logic [WAYS-1:0][ENTRY_W-1:0] word_t;

	// input side
	logic                      accept;
	logic [VERTEX_W-1:0]       vm_in;
	logic [SET_INDEX_BITS-1:0] set_in;
	logic [TAG_W-1:0]          tag_in;

	// lookup stage
	logic                      valid_s1;
	logic                      cmd_s1;
	logic [VERTEX_W-1:0]       vertex_s1;
	logic [SET_INDEX_BITS-1:0] set_s1;
	logic [TAG_W-1:0]          tag_s1;

	// block state
	way_t                      victim_q;
	epoch_t                    epoch_q;
	logic                      clear_q;
	logic [SET_INDEX_BITS-1:0] clr_addr_q;

	// write forward of the last memory write
	logic                      fwd_valid_q;
	logic [SET_INDEX_BITS-1:0] fwd_addr_q;
	word_t                     fwd_data_q;

	word_t                     rd_data;
	word_t                     cur_word;
	word_t                     new_word;
	logic                      hit;
	logic                      is_vertex_s1;
	logic                      miss_s1;
	logic                      end_s1;
	logic                      wr_en;
	logic [SET_INDEX_BITS-1:0] wr_addr;
	word_t                     wr_data;

	logic                      push;
	out_item_t                 push_item;
	logic [OUT_CNT_W-1:0]      level;
	logic                      end_block;

	// bits above VERTEX_BITS are dropped before anything else
	assign vm_in  = items.vertex_in & VMASK;
	assign set_in = vm_in[SET_INDEX_BITS-1:0];
	// with no tag bits every vertex compares as the cleared all-ones tag
	assign tag_in = HAS_TAG ? TAG_W'(vm_in >> SET_INDEX_BITS) : '1;

	// an end marker that wraps the epoch starts a clearing pass next; hold items off
	assign end_block   = valid_s1 && (cmd_s1 == CMD_END) && (epoch_q == EPOCH_LAST);
	assign items.ready = !clear_q && !end_block &&
		((level + OUT_CNT_W'(valid_s1)) < OUT_CNT_W'(OUT_DEPTH));
	assign accept      = items.valid && items.ready;

	sadf_tag_ram #(
		.SET_BITS (SET_INDEX_BITS),
		.WORD_W   (WORD_W)
	) u_tag_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (set_in),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= items.cmd;
			vertex_s1 <= vm_in;
			set_s1    <= set_in;
			tag_s1    <= tag_in;
		end
		fwd_addr_q <= wr_addr;
		fwd_data_q <= wr_data;
	end

	// the item ahead may have just written this set; its data is not in rd_data yet
	assign cur_word = (fwd_valid_q && (fwd_addr_q == set_s1)) ? fwd_data_q : rd_data;

	sadf_match #(
		.TAG_W (TAG_W)
	) u_match (
		.word     (cur_word),
		.tag      (tag_s1),
		.epoch    (epoch_q),
		.victim   (victim_q),
		.hit      (hit),
		.new_word (new_word)
	);

	assign is_vertex_s1 = valid_s1 && (cmd_s1 == CMD_VERTEX);
	assign end_s1       = valid_s1 && (cmd_s1 == CMD_END);
	assign miss_s1      = is_vertex_s1 && !hit;

	// clearing pass writes epoch zero everywhere, which never matches a live epoch
	assign wr_en   = clear_q || miss_s1;
	assign wr_addr = clear_q ? clr_addr_q : set_s1;
	assign wr_data = clear_q ? '0 : new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			victim_q    <= '0;
			epoch_q     <= EPOCH_FIRST;
			clear_q     <= 1'b1;
			clr_addr_q  <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept;
			fwd_valid_q <= wr_en;
			if (end_s1) begin
				victim_q <= '0;
			end else if (miss_s1) begin
				victim_q <= victim_q + WAY_W'(1);
			end
			if (clear_q) begin
				clr_addr_q <= clr_addr_q + SET_INDEX_BITS'(1);
				if (clr_addr_q == '1) begin
					clear_q <= 1'b0;
					epoch_q <= EPOCH_FIRST;
				end
			end else if (end_s1) begin
				if (epoch_q == EPOCH_LAST) begin
					clear_q    <= 1'b1;
					clr_addr_q <= '0;
				end else begin
					epoch_q <= epoch_q + epoch_t'(1);
				end
			end
		end
	end

	// end markers always forward; vertices forward only on a miss
	assign push = end_s1 || miss_s1;
	always_comb begin
		if (cmd_s1 == CMD_END) begin
			push_item.vertex_out = '0;
			push_item.is_end     = 1'b1;
		end else begin
			push_item.vertex_out = vertex_s1;
			push_item.is_end     = 1'b0;
		end
	end

	sadf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.level     (level),
		.results   (results)
	);

`ifndef SYNTH
	a_no_lookup_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !valid_s1 && !accept)
		else $error("lookup overlaps the clearing pass");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level < OUT_CNT_W'(OUT_DEPTH)) || (results.valid && results.ready))
		else $error("result queue overflow");

	a_victim_reset_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		end_s1 |=> victim_q == '0)
		else $error("victim pointer not reset by end marker");

	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_q |-> epoch_q != '0)
		else $error("live epoch equals the cleared mark");
`endif

endmodule

[tb/sadf_filter_checker.sv]
`timescale 1ns / 1ps
// sadf_filter_checker: watches both channels of the duplicate filter and predicts its results
// depends on sadf_pkg; instantiated beside the block by set_assoc_duplicate_filter_tb
module sadf_filter_checker import sadf_pkg::*; #(
	parameter int SET_INDEX_BITS = 14,
	parameter int VERTEX_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  logic                item_cmd,
	input  logic [VERTEX_W-1:0] item_vertex,
	input  logic                result_valid,
	input  logic                result_ready,
	input  logic [VERTEX_W-1:0] result_vertex,
	input  logic                result_is_end,
	output int                  fail_count,
	output int                  pending,
	output int                  passed_count,
	output int                  dropped_count,
	output int                  end_count
);

	localparam int TAG_W = (VERTEX_BITS > SET_INDEX_BITS) ? VERTEX_BITS - SET_INDEX_BITS : 0;
	localparam logic [31:0] TAG_MASK    = 32'((64'd1 << TAG_W) - 64'd1);
	localparam logic [31:0] VERTEX_MASK = 32'((64'd1 << VERTEX_BITS) - 64'd1);
	localparam logic [31:0] SET_MASK    = 32'((64'd1 << SET_INDEX_BITS) - 64'd1);

	// key is set * WAYS + way; a missing key is a cleared (all ones) entry
	logic [31:0] way_tag_store [int unsigned];
	way_t        victim_way = '0;
	out_item_t   forwarded_q [$];
	int          n_fail, n_passed, n_dropped, n_end;

	function automatic int unsigned tag_key(way_t w, logic [31:0] set);
		return set * WAYS + w;
	endfunction

	function automatic logic [31:0] stored_tag(way_t w, logic [31:0] set);
		if (way_tag_store.exists(tag_key(w, set)))
			return way_tag_store[tag_key(w, set)];
		return TAG_MASK;
	endfunction

	task automatic report_mismatch(input string what);
		n_fail++;
		if (n_fail <= 40)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// filters one accepted transaction and queues the result it should cause
	task automatic filter_item(input logic cmd, input logic [31:0] vin);
		logic [31:0] v, set, tag;
		logic        hit;
		out_item_t   res;
		v = vin & VERTEX_MASK;
		if (cmd == CMD_END) begin
			way_tag_store.delete();
			victim_way     = '0;
			res.vertex_out = '0;
			res.is_end     = 1'b1;
			forwarded_q.push_back(res);
			n_end++;
		end else begin
			set = v & SET_MASK;
			tag = 32'(64'(v) >> SET_INDEX_BITS) & TAG_MASK;
			hit = 1'b0;
			for (int w = 0; w < WAYS; w++)
				if (stored_tag(way_t'(w), set) == tag)
					hit = 1'b1;
			if (hit) begin
				n_dropped++;
			end else begin
				way_tag_store[tag_key(victim_way, set)] = tag;
				victim_way     = victim_way + 1'b1;
				res.vertex_out = v;
				res.is_end     = 1'b0;
				forwarded_q.push_back(res);
				n_passed++;
			end
		end
	endtask

	task automatic check_result();
		out_item_t want;
		if (forwarded_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result vertex %08h is_end %0b",
				result_vertex, result_is_end));
		end else begin
			want = forwarded_q.pop_front();
			if (result_is_end !== want.is_end)
				report_mismatch($sformatf("is_end %0b, expected %0b (vertex %08h)",
					result_is_end, want.is_end, want.vertex_out));
			if (result_vertex !== want.vertex_out)
				report_mismatch($sformatf("vertex_out %08h, expected %08h",
					result_vertex, want.vertex_out));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_tag_store.delete();
			victim_way = '0;
			forwarded_q.delete();
		end else begin
			if (result_valid && result_ready)
				check_result();
			if (item_valid && item_ready)
				filter_item(item_cmd, item_vertex);
		end
		pending       <= forwarded_q.size();
		fail_count    <= n_fail;
		passed_count  <= n_passed;
		dropped_count <= n_dropped;
		end_count     <= n_end;
	end

endmodule

[tb/set_assoc_duplicate_filter_tb.sv]
`timescale 1ns / 1ps
// set_assoc_duplicate_filter_tb: stimulus and verdict for the four-way vertex duplicate filter
// depends on sadf_pkg, sadf_in_if, sadf_out_if, sadf_filter_checker and the block itself
module set_assoc_duplicate_filter_tb;
	import sadf_pkg::*;

	localparam int SET_BITS       = 14;
	localparam int VTX_BITS       = 32;
	localparam int TAG_BITS       = VTX_BITS - SET_BITS;
	localparam int RANDOM_ITEMS   = 730;
	// last stretch of the random part runs with no idling on either side
	localparam int STEADY_TAIL    = 150;
	localparam int SQUEEZE_AT     = 220;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 24;
	localparam logic [TAG_BITS-1:0] TAG_ONES = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sadf_in_if  items_ch ();
	sadf_out_if results_ch ();

	int fail_count, pending_results, passed_count, dropped_count, end_count;

	// idling control shared by the sender and receiver processes
	bit idle_on        = 1'b0;
	bit steady_tail    = 1'b0;
	bit squeeze_req    = 1'b0;
	bit squeeze_active = 1'b0;
	bit squeeze_done   = 1'b0;

	// vertices sent lately, replayed to hit the tag ways
	logic [31:0]         recent_vertices [$];
	// a handful of sets that see most traffic, so ways fill and get evicted
	logic [SET_BITS-1:0] hot_sets [8];
	int                  items_sent = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	set_assoc_duplicate_filter #(
		.SET_INDEX_BITS(SET_BITS),
		.VERTEX_BITS   (VTX_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.results(results_ch)
	);

	sadf_filter_checker #(
		.SET_INDEX_BITS(SET_BITS),
		.VERTEX_BITS   (VTX_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (items_ch.valid),
		.item_ready   (items_ch.ready),
		.item_cmd     (items_ch.cmd),
		.item_vertex  (items_ch.vertex_in),
		.result_valid (results_ch.valid),
		.result_ready (results_ch.ready),
		.result_vertex(results_ch.vertex_out),
		.result_is_end(results_ch.is_end),
		.fail_count   (fail_count),
		.pending      (pending_results),
		.passed_count (passed_count),
		.dropped_count(dropped_count),
		.end_count    (end_count)
	);

	// hard stop; covers the clearing pass after reset many times over
	initial begin
		#2_000_000;
		$display("timeout: results still owed %0d", pending_results);
		$display("[FAIL] regression broken");
		$finish;
	end

	// holds valid high with the item until the transaction happens; valid is left high
	// so a following item can go out back to back
	task automatic offer_item(input logic cmd, input logic [31:0] vertex);
		items_ch.valid     <= 1'b1;
		items_ch.cmd       <= cmd;
		items_ch.vertex_in <= vertex;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
		items_sent++;
		if (cmd == CMD_VERTEX) begin
			recent_vertices.push_back(vertex);
			if (recent_vertices.size() > 24)
				void'(recent_vertices.pop_front());
		end
	endtask

	// random idle burst on the sender side; none while the receiver is squeezed,
	// so the result queue really fills and the block has to stall items
	task automatic sender_gap();
		if (idle_on && !steady_tail && !squeeze_active && $urandom_range(0, 3) == 0) begin
			items_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic send(input logic cmd, input logic [31:0] vertex);
		offer_item(cmd, vertex);
		sender_gap();
	endtask

	// mostly well-formed traffic: replays, conflicts in hot sets, rare level ends
	task automatic pick_random_item(output logic cmd, output logic [31:0] vertex);
		int unsigned         roll;
		logic [TAG_BITS-1:0] tag;
		logic [SET_BITS-1:0] set;
		roll = $urandom_range(0, 99);
		cmd  = CMD_VERTEX;
		set  = hot_sets[$urandom_range(0, 7)];
		tag  = TAG_BITS'($urandom_range(0, 9));
		if (roll < 35 && recent_vertices.size() != 0) begin
			vertex = recent_vertices[$urandom_range(0, recent_vertices.size() - 1)];
		end else begin
			// below 62: hot set with a tag from a small alphabet, keeps ways churning
			if (roll >= 62 && roll < 65) begin
				tag = TAG_ONES;
			end else if (roll >= 65 && roll < 82) begin
				tag = TAG_BITS'($urandom);
			end else if (roll >= 82) begin
				set = SET_BITS'($urandom);
				tag = TAG_BITS'($urandom);
			end
			vertex = {tag, set};
			if (roll >= 97) begin
				cmd    = CMD_END;
				vertex = $urandom;
			end
		end
	endtask

	// receiver: random stall bursts, one long squeeze, always ready in the tail
	initial begin
		results_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				results_ch.ready <= 1'b0;
				squeeze_active = 1'b1;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_active = 1'b0;
				squeeze_done   = 1'b1;
			end else if (idle_on && !steady_tail && $urandom_range(0, 5) == 0) begin
				results_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				results_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// sender and verdict
	initial begin
		logic        cmd;
		logic [31:0] vertex;
		items_ch.valid     <= 1'b0;
		items_ch.cmd       <= CMD_VERTEX;
		items_ch.vertex_in <= '0;
		for (int i = 0; i < 8; i++)
			hot_sets[i] = SET_BITS'($urandom);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		idle_on = ($urandom_range(0, 1) != 0);

		// directed: first sighting passes, second is dropped
		send(CMD_VERTEX, 32'h0000_0000);
		send(CMD_VERTEX, 32'h0000_0000);
		// all-ones tag matches the cleared ways and is dropped
		send(CMD_VERTEX, 32'hFFFF_FFFF);
		send(CMD_VERTEX, {TAG_ONES, {SET_BITS{1'b0}}});
		// top set index, tag zero
		send(CMD_VERTEX, 32'h0000_3FFF);
		send(CMD_VERTEX, 32'h0000_3FFF);
		// five tags into one set: the round-robin pointer evicts the oldest
		for (int t = 1; t <= 5; t++)
			send(CMD_VERTEX, {TAG_BITS'(t), SET_BITS'(14'h0155)});
		send(CMD_VERTEX, {TAG_BITS'(1), SET_BITS'(14'h0155)});
		// level end ignores vertex_in, clears everything, back to back ends too
		send(CMD_END, 32'hDEAD_BEEF);
		send(CMD_VERTEX, 32'h0000_0000);
		send(CMD_END, 32'h0000_0000);
		send(CMD_END, 32'hFFFF_FFFF);
		send(CMD_VERTEX, 32'hFFFF_C000);
		send(CMD_VERTEX, 32'h8000_0001);
		send(CMD_VERTEX, 32'h7FFF_FFFE);
		send(CMD_VERTEX, 32'h8000_0001);
		send(CMD_VERTEX, 32'hFFFF_FFFE);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// stretches of 40 items either idle at random or run flat out
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (n == SQUEEZE_AT)
				squeeze_req = 1'b1;
			if (n == RANDOM_ITEMS - STEADY_TAIL)
				steady_tail = 1'b1;
			pick_random_item(cmd, vertex);
			send(cmd, vertex);
		end
		items_ch.valid <= 1'b0;

		// drain, then give a dropped or stray result time to show up
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results != 0)
			$display("results still owed at end: %0d", pending_results);
		$display("sent %0d transactions; %0d vertices passed, %0d dropped as seen",
			items_sent, passed_count, dropped_count);
		$display("%0d level ends forwarded; receiver squeezed once for %0d cycles",
			end_count, SQUEEZE_CYCLES);
		if (fail_count == 0 && pending_results == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
